@@ design/lpf_pkg.sv @@
// Shared types and constants for the lidar point filter.
package lpf_pkg;

   localparam int DECIM_W    = 7;
   localparam int INDEX_W    = 6;
   localparam int BLIND_W    = 16;
   localparam int BLIND_SQ_W = 2 * BLIND_W;
   localparam int REFL_W     = 8;
   localparam int STAMP_W    = 48;
   localparam int REL_W      = 32;
   localparam int CSR_DATA_W = 16;

   localparam logic [DECIM_W-1:0] DECIM_MAX   = 7'd64;
   localparam logic [DECIM_W-1:0] DECIM_RESET = 7'd1;
   localparam logic [REFL_W-1:0]  MAX_INT_RESET = 8'd255;

   typedef enum logic [1:0] {
      CSR_DECIMATION     = 2'd0,
      CSR_BLIND_DISTANCE = 2'd1,
      CSR_MIN_INTENSITY  = 2'd2,
      CSR_MAX_INTENSITY  = 2'd3
   } csr_index_type;

endpackage

@@ design/lpf_range_gate.sv @@
// Squared-range stage: registered coordinate squares, then sum and blind-zone compare.
module lpf_range_gate #(
   parameter int COORD_BITS = 24
) (
   input  logic                              clock,
   input  logic                              load,
   input  logic [COORD_BITS-1:0]             pos_x,
   input  logic [COORD_BITS-1:0]             pos_y,
   input  logic [COORD_BITS-1:0]             pos_z,
   input  logic [lpf_pkg::BLIND_W-1:0]       blind_distance,
   output logic                              far_enough
);

   localparam int SQ_W  = 2 * COORD_BITS;
   localparam int SUM_W = SQ_W + 2;

   logic [COORD_BITS-1:0]            mag_x, mag_y, mag_z;
   logic [SQ_W-1:0]                  sq_x_in, sq_y_in, sq_z_in;
   logic [SQ_W-1:0]                  sq_x_ff, sq_y_ff, sq_z_ff;
   logic [lpf_pkg::BLIND_SQ_W-1:0]   blind_sq_in, blind_sq_ff;
   logic [SUM_W-1:0]                 range_sq;

   // two's complement magnitude; the most negative value still fits unsigned
   assign mag_x = pos_x[COORD_BITS-1] ? (~pos_x + COORD_BITS'(1)) : pos_x;
   assign mag_y = pos_y[COORD_BITS-1] ? (~pos_y + COORD_BITS'(1)) : pos_y;
   assign mag_z = pos_z[COORD_BITS-1] ? (~pos_z + COORD_BITS'(1)) : pos_z;

   assign sq_x_in     = SQ_W'(mag_x) * SQ_W'(mag_x);
   assign sq_y_in     = SQ_W'(mag_y) * SQ_W'(mag_y);
   assign sq_z_in     = SQ_W'(mag_z) * SQ_W'(mag_z);
   assign blind_sq_in = lpf_pkg::BLIND_SQ_W'(blind_distance)
                      * lpf_pkg::BLIND_SQ_W'(blind_distance);

   always_ff @(posedge clock) begin
      if (load) begin
         sq_x_ff     <= sq_x_in;
         sq_y_ff     <= sq_y_in;
         sq_z_ff     <= sq_z_in;
         blind_sq_ff <= blind_sq_in;
      end
   end

   assign range_sq   = SUM_W'(sq_x_ff) + SUM_W'(sq_y_ff) + SUM_W'(sq_z_ff);
   assign far_enough = (range_sq >= SUM_W'(blind_sq_ff));

endmodule

@@ design/lidar_point_filter_top.sv @@
// Lidar point filter top level: decimation, blind-zone, intensity window, relative time.
//
//  channel  | dir | handshake             | payload
//  ---------+-----+-----------------------+------------------------------------------
//  req_     | in  | req_tvalid/req_tready | tdata point fields, tuser cloud_first
//  rsp_     | out | rsp_tvalid/rsp_tready | tdata kept point, relative and start time
//  csr_     | in  | csr_valid/csr_ready   | csr_index, csr_wdata (always ready)
//
// One word per clock sustained while rsp_tready stays high; a kept point's word passes
// through the input register, square register and result register in turn.
// The three coordinate multipliers feeding the square register set the stage depth.
// A dropped point leaves no word; stages hold under rsp_tready low and refill bubbles.
// Synchronous active-high reset clears valids, point index and start time and sets config defaults.
module lidar_point_filter_top #(
   parameter int COORD_BITS = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // req_tdata: pos_x, pos_y, pos_z, coords_valid, reflectivity, stamp_us, zero pad
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((3*COORD_BITS+57+7)/8)*8-1:0]  req_tdata,
   // req_tuser: cloud_first
   input  logic                                  req_tuser,
   // rsp_tdata: out_x, out_y, out_z, out_reflectivity, rel_time_us, cloud_start_us, pad
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [((3*COORD_BITS+88+7)/8)*8-1:0]  rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  lpf_pkg::csr_index_type                csr_index,
   input  logic [lpf_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int C      = COORD_BITS;
   localparam int RSP_W  = ((3*COORD_BITS+88+7)/8)*8;
   localparam int RAW_W  = 3*COORD_BITS + 88;
   localparam int VLD_B  = 3*C;
   localparam int REFL_L = 3*C + 1;
   localparam int STMP_L = REFL_L + lpf_pkg::REFL_W;

   // configuration
   logic [lpf_pkg::DECIM_W-1:0] decimation_ff, decimation_in;
   logic [lpf_pkg::BLIND_W-1:0] blind_ff, blind_in;
   logic [lpf_pkg::REFL_W-1:0]  min_int_ff, min_int_in;
   logic [lpf_pkg::REFL_W-1:0]  max_int_ff, max_int_in;

   assign csr_ready = 1'b1;

   always_comb begin
      decimation_in = decimation_ff;
      blind_in      = blind_ff;
      min_int_in    = min_int_ff;
      max_int_in    = max_int_ff;
      if (csr_valid) begin
         case (csr_index)
            lpf_pkg::CSR_DECIMATION:     decimation_in = csr_wdata[lpf_pkg::DECIM_W-1:0];
            lpf_pkg::CSR_BLIND_DISTANCE: blind_in      = csr_wdata;
            lpf_pkg::CSR_MIN_INTENSITY:  min_int_in    = csr_wdata[lpf_pkg::REFL_W-1:0];
            lpf_pkg::CSR_MAX_INTENSITY:  max_int_in    = csr_wdata[lpf_pkg::REFL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decimation_ff <= lpf_pkg::DECIM_RESET;
         blind_ff      <= '0;
         min_int_ff    <= '0;
         max_int_ff    <= lpf_pkg::MAX_INT_RESET;
      end else begin
         decimation_ff <= decimation_in;
         blind_ff      <= blind_in;
         min_int_ff    <= min_int_in;
         max_int_ff    <= max_int_in;
      end
   end

   // pipeline flow control
   logic s1_vld_ff, s1_vld_in, s2_vld_ff, s2_vld_in, rsp_vld_ff, rsp_vld_in;
   logic s1_adv, s2_adv, s2_ld, rsp_ld;
   logic far_enough;
   logic s2_cand_ff;

   assign rsp_ld     = !rsp_vld_ff || rsp_tready;
   assign s2_adv     = s2_vld_ff && rsp_ld;
   assign s2_ld      = !s2_vld_ff || s2_adv;
   assign s1_adv     = s1_vld_ff && s2_ld;
   assign req_tready = !s1_vld_ff || s1_adv;

   always_comb begin
      s1_vld_in  = req_tready ? req_tvalid : s1_vld_ff;
      s2_vld_in  = s2_ld ? s1_adv : s2_vld_ff;
      rsp_vld_in = rsp_vld_ff;
      if (rsp_ld) begin
         rsp_vld_in = s2_vld_ff && s2_cand_ff && far_enough;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         s2_vld_ff  <= s2_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // stage 1: input register
   logic [C-1:0]                s1_x_ff, s1_y_ff, s1_z_ff;
   logic                        s1_valid_ff, s1_first_ff;
   logic [lpf_pkg::REFL_W-1:0]  s1_refl_ff;
   logic [lpf_pkg::STAMP_W-1:0] s1_stamp_ff;

   always_ff @(posedge clock) begin
      if (req_tready) begin
         s1_x_ff     <= req_tdata[C-1:0];
         s1_y_ff     <= req_tdata[2*C-1:C];
         s1_z_ff     <= req_tdata[3*C-1:2*C];
         s1_valid_ff <= req_tdata[VLD_B];
         s1_refl_ff  <= req_tdata[STMP_L-1:REFL_L];
         s1_stamp_ff <= req_tdata[STMP_L+lpf_pkg::STAMP_W-1:STMP_L];
         s1_first_ff <= req_tuser;
      end
   end

   // cloud state, updated as an item leaves stage 1
   logic [lpf_pkg::INDEX_W-1:0] point_index_ff, point_index_in, idx_cur;
   logic [lpf_pkg::STAMP_W-1:0] start_stamp_ff, start_stamp_in, start_cur, stamp_diff;
   logic [lpf_pkg::DECIM_W-1:0] dec_eff, idx_inc;
   logic [lpf_pkg::REL_W-1:0]   rel_cur;
   logic                        cand_cur;

   always_comb begin
      if (decimation_ff == '0) begin
         dec_eff = lpf_pkg::DECIM_RESET;
      end else if (decimation_ff > lpf_pkg::DECIM_MAX) begin
         dec_eff = lpf_pkg::DECIM_MAX;
      end else begin
         dec_eff = decimation_ff;
      end
      idx_cur   = s1_first_ff ? '0 : point_index_ff;
      start_cur = s1_first_ff ? s1_stamp_ff : start_stamp_ff;
      idx_inc   = {1'b0, idx_cur} + lpf_pkg::DECIM_W'(1);

      point_index_in = point_index_ff;
      start_stamp_in = start_stamp_ff;
      if (s1_adv) begin
         point_index_in = (idx_inc >= dec_eff) ? '0 : idx_inc[lpf_pkg::INDEX_W-1:0];
         start_stamp_in = start_cur;
      end

      stamp_diff = s1_stamp_ff - start_cur;
      if (s1_stamp_ff < start_cur) begin
         rel_cur = '0;
      end else if (|stamp_diff[lpf_pkg::STAMP_W-1:lpf_pkg::REL_W]) begin
         rel_cur = '1;
      end else begin
         rel_cur = stamp_diff[lpf_pkg::REL_W-1:0];
      end

      cand_cur = (idx_cur == '0) && s1_valid_ff
              && (s1_refl_ff >= min_int_ff) && (s1_refl_ff <= max_int_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_index_ff <= '0;
         start_stamp_ff <= '0;
      end else begin
         point_index_ff <= point_index_in;
         start_stamp_ff <= start_stamp_in;
      end
   end

   // stage 2: squares live in the range gate, the rest here
   logic [C-1:0]                s2_x_ff, s2_y_ff, s2_z_ff;
   logic [lpf_pkg::REFL_W-1:0]  s2_refl_ff;
   logic [lpf_pkg::REL_W-1:0]   s2_rel_ff;
   logic [lpf_pkg::STAMP_W-1:0] s2_start_ff;

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_cand_ff  <= cand_cur;
         s2_x_ff     <= s1_x_ff;
         s2_y_ff     <= s1_y_ff;
         s2_z_ff     <= s1_z_ff;
         s2_refl_ff  <= s1_refl_ff;
         s2_rel_ff   <= rel_cur;
         s2_start_ff <= start_cur;
      end
   end

   lpf_range_gate #(
      .COORD_BITS (COORD_BITS)
   ) u_range_gate (
      .clock          (clock),
      .load           (s1_adv),
      .pos_x          (s1_x_ff),
      .pos_y          (s1_y_ff),
      .pos_z          (s1_z_ff),
      .blind_distance (blind_ff),
      .far_enough     (far_enough)
   );

   // result register
   logic [RAW_W-1:0] rsp_word_ff, rsp_word_in;

   assign rsp_word_in = {s2_start_ff, s2_rel_ff, s2_refl_ff, s2_z_ff, s2_y_ff, s2_x_ff};

   always_ff @(posedge clock) begin
      if (rsp_ld && s2_vld_ff) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = RSP_W'(rsp_word_ff);

   // checks
   a_rsp_from_s2: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(s2_vld_ff))
      else $error("result word appeared without an item in stage 2");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !s1_vld_ff |-> req_tready)
      else $error("input refused while stage 1 is empty");

   a_s2_hold: assert property (@(posedge clock) disable iff (reset)
      (s2_vld_ff && !s2_adv) |=> (s2_vld_ff && $stable(s2_rel_ff) && $stable(s2_cand_ff)))
      else $error("stalled stage 2 item changed");

   a_cloud_start: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_first_ff) |=> (start_stamp_ff == $past(s1_stamp_ff)
                                   && point_index_ff == $past(point_index_in)))
      else $error("cloud start not latched from first point");

endmodule

@@ verif/lidar_point_filter_top_tb.sv @@
// Self-checking testbench for the lidar point filter: directed and random point clouds.
`timescale 1ns / 1ps

module lidar_point_filter_top_tb;

   localparam int COORD_W        = 24;
   localparam int REQ_W          = ((3*COORD_W+57+7)/8)*8;
   localparam int RSP_W          = ((3*COORD_W+88+7)/8)*8;
   localparam int SETTLE_CYCLES  = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RAND_PHASES    = 9;
   localparam int PHASE_POINTS   = 42;
   localparam int EXP_DEPTH      = 1024;
   localparam int EXP_AW         = 10;

   // rsp_tdata field offsets, lowest bit up
   localparam int RX_LO     = 0;
   localparam int RY_LO     = COORD_W;
   localparam int RZ_LO     = 2*COORD_W;
   localparam int RREFL_LO  = 3*COORD_W;
   localparam int RREL_LO   = RREFL_LO + lpf_pkg::REFL_W;
   localparam int RSTART_LO = RREL_LO + lpf_pkg::REL_W;

   typedef struct {
      logic signed [COORD_W-1:0]       x;
      logic signed [COORD_W-1:0]       y;
      logic signed [COORD_W-1:0]       z;
      logic                            valid;
      logic [lpf_pkg::REFL_W-1:0]      refl;
      logic [lpf_pkg::STAMP_W-1:0]     stamp;
      logic                            first;
   } lidar_point_type;

   typedef struct {
      logic signed [COORD_W-1:0]       x;
      logic signed [COORD_W-1:0]       y;
      logic signed [COORD_W-1:0]       z;
      logic [lpf_pkg::REFL_W-1:0]      refl;
      logic [lpf_pkg::REL_W-1:0]       rel;
      logic [lpf_pkg::STAMP_W-1:0]     start;
   } kept_point_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [REQ_W-1:0]               req_tdata = '0;
   logic                           req_tuser = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [RSP_W-1:0]               rsp_tdata;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   lpf_pkg::csr_index_type         csr_index = lpf_pkg::CSR_DECIMATION;
   logic [lpf_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // filter settings and per-cloud state as the block should hold them
   logic [lpf_pkg::DECIM_W-1:0]  cfg_decim = lpf_pkg::DECIM_RESET;
   logic [lpf_pkg::BLIND_W-1:0]  cfg_blind = '0;
   logic [lpf_pkg::REFL_W-1:0]   cfg_min_refl = '0;
   logic [lpf_pkg::REFL_W-1:0]   cfg_max_refl = lpf_pkg::MAX_INT_RESET;
   logic [lpf_pkg::INDEX_W-1:0]  point_idx = '0;
   logic [lpf_pkg::STAMP_W-1:0]  cloud_start = '0;

   // expected words, kept in order in a ring
   kept_point_type kept_mem [EXP_DEPTH];
   int unsigned    exp_wr_total = 0;
   int unsigned    exp_rd_total = 0;
   int             n_errors = 0;
   int             quiet_cycles = 0;
   bit             req_burst = 1'b0;
   bit             rsp_burst = 1'b0;

   lidar_point_filter_top #(
      .COORD_BITS (COORD_W)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [63:0] coord_sq(logic signed [COORD_W-1:0] c);
      logic [63:0] mag;
      mag = '0;
      mag[COORD_W-1:0] = c;
      if (c[COORD_W-1]) begin
         mag = (64'd1 << COORD_W) - mag;
      end
      return mag * mag;
   endfunction

   function automatic int unsigned pending_words();
      return exp_wr_total - exp_rd_total;
   endfunction

   task automatic filter_point(input lidar_point_type p);
      logic [lpf_pkg::DECIM_W-1:0] dec;
      logic [lpf_pkg::INDEX_W-1:0] idx;
      int unsigned                 nxt;
      logic [63:0]                 range_sq;
      logic [63:0]                 blind_sq;
      logic [lpf_pkg::STAMP_W-1:0] dt;
      kept_point_type              r;
      dec = cfg_decim;
      if (dec == 0) begin
         dec = lpf_pkg::DECIM_RESET;
      end
      if (dec > lpf_pkg::DECIM_MAX) begin
         dec = lpf_pkg::DECIM_MAX;
      end
      if (p.first) begin
         cloud_start = p.stamp;
         point_idx   = '0;
      end
      idx = point_idx;
      nxt = idx + 1;
      point_idx = (nxt >= dec) ? '0 : lpf_pkg::INDEX_W'(nxt);
      if (idx != 0 || !p.valid) begin
         return;
      end
      range_sq = coord_sq(p.x) + coord_sq(p.y) + coord_sq(p.z);
      blind_sq = 64'(cfg_blind) * 64'(cfg_blind);
      if (range_sq < blind_sq) begin
         return;
      end
      if (p.refl < cfg_min_refl || p.refl > cfg_max_refl) begin
         return;
      end
      r.x = p.x;
      r.y = p.y;
      r.z = p.z;
      r.refl = p.refl;
      r.start = cloud_start;
      if (p.stamp < cloud_start) begin
         r.rel = '0;
      end else begin
         dt = p.stamp - cloud_start;
         r.rel = (dt > 48'hFFFF_FFFF) ? '1 : dt[lpf_pkg::REL_W-1:0];
      end
      kept_mem[exp_wr_total[EXP_AW-1:0]] = r;
      exp_wr_total++;
   endtask

   function automatic lidar_point_type make_point(int x, int y, int z, bit valid, int refl,
                                                  logic [lpf_pkg::STAMP_W-1:0] stamp,
                                                  bit first);
      lidar_point_type p;
      p.x = x[COORD_W-1:0];
      p.y = y[COORD_W-1:0];
      p.z = z[COORD_W-1:0];
      p.valid = valid;
      p.refl = refl[lpf_pkg::REFL_W-1:0];
      p.stamp = stamp;
      p.first = first;
      return p;
   endfunction

   function automatic logic [lpf_pkg::STAMP_W-1:0] rand_stamp();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[lpf_pkg::STAMP_W-1:0];
   endfunction

   function automatic logic signed [COORD_W-1:0] rand_coord(bit wide);
      int v;
      if (wide) begin
         v = $urandom;
      end else begin
         v = int'($urandom_range(0, 140000)) - 70000;
      end
      return v[COORD_W-1:0];
   endfunction

   task automatic send_point(input lidar_point_type p);
      int unsigned gap;
      gap = req_burst ? 0 : $urandom_range(0, 7);
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'({p.stamp, p.refl, p.valid, p.z, p.y, p.x});
      req_tuser  <= p.first;
      do @(posedge clock); while (!req_tready);
      filter_point(p);
   endtask

   task automatic write_csr(input lpf_pkg::csr_index_type idx,
                            input logic [lpf_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         lpf_pkg::CSR_DECIMATION:     cfg_decim    = val[lpf_pkg::DECIM_W-1:0];
         lpf_pkg::CSR_BLIND_DISTANCE: cfg_blind    = val[lpf_pkg::BLIND_W-1:0];
         lpf_pkg::CSR_MIN_INTENSITY:  cfg_min_refl = val[lpf_pkg::REFL_W-1:0];
         lpf_pkg::CSR_MAX_INTENSITY:  cfg_max_refl = val[lpf_pkg::REFL_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // stop sending, wait for every expected word, then let dropped points clear the pipe
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_words() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         n_errors++;
      end
   endtask

   // receiver: random stall before each word, none in burst phases
   initial begin
      int unsigned stall;
      forever begin
         stall = rsp_burst ? 0 : $urandom_range(0, 7);
         @(negedge clock);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin : check_words
      kept_point_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_words() == 0) begin
            $error("unexpected word 0x%0h", rsp_tdata);
            n_errors++;
         end else begin
            want = kept_mem[exp_rd_total[EXP_AW-1:0]];
            exp_rd_total++;
            check_field("out_x", want.x[COORD_W-1:0], rsp_tdata[RX_LO +: COORD_W]);
            check_field("out_y", want.y[COORD_W-1:0], rsp_tdata[RY_LO +: COORD_W]);
            check_field("out_z", want.z[COORD_W-1:0], rsp_tdata[RZ_LO +: COORD_W]);
            check_field("out_reflectivity", want.refl,
                        rsp_tdata[RREFL_LO +: lpf_pkg::REFL_W]);
            check_field("rel_time_us", want.rel, rsp_tdata[RREL_LO +: lpf_pkg::REL_W]);
            check_field("cloud_start_us", want.start,
                        rsp_tdata[RSTART_LO +: lpf_pkg::STAMP_W]);
         end
      end
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("lidar_point_filter_top_tb failed");
      $finish;
   end

   task automatic test_reset_defaults();
      // points ahead of any first mark use the reset start time of zero
      send_point(make_point(8388607, -8388608, 0, 1'b1, 0, 48'd5, 1'b0));
      send_point(make_point(-1, -1, -1, 1'b0, 255, 48'hFFFF_FFFF_FFFF, 1'b0));
      send_point(make_point(0, 0, 0, 1'b1, 255, 48'h1000_0000_0000, 1'b1));
      // stamp earlier than cloud start clamps to zero
      send_point(make_point(12, -34, 56, 1'b1, 77, 48'h0FFF_FFFF_FFFF, 1'b0));
      // huge difference saturates
      send_point(make_point(-5, 6, -7, 1'b1, 200, 48'hFFFF_FFFF_FFFF, 1'b0));
      send_point(make_point(-8388608, -8388608, -8388608, 1'b1, 128,
                            48'h1000_0000_04D2, 1'b0));
   endtask

   task automatic test_blind_zone();
      settle();
      write_csr(lpf_pkg::CSR_BLIND_DISTANCE, 16'd1000);
      send_point(make_point(1000, 0, 0, 1'b1, 10, 48'd100, 1'b1));
      send_point(make_point(0, -999, 0, 1'b1, 10, 48'd101, 1'b0));
      send_point(make_point(577, 577, 577, 1'b1, 10, 48'd102, 1'b0));
      send_point(make_point(-578, 578, -578, 1'b1, 10, 48'd103, 1'b0));
      settle();
      write_csr(lpf_pkg::CSR_BLIND_DISTANCE, 16'hFFFF);
      send_point(make_point(65535, 0, 0, 1'b1, 10, 48'd200, 1'b1));
      send_point(make_point(0, 0, -65534, 1'b1, 10, 48'd201, 1'b0));
   endtask

   task automatic test_intensity_window();
      settle();
      write_csr(lpf_pkg::CSR_BLIND_DISTANCE, 16'd0);
      write_csr(lpf_pkg::CSR_MIN_INTENSITY, 16'd10);
      write_csr(lpf_pkg::CSR_MAX_INTENSITY, 16'd20);
      send_point(make_point(1, 2, 3, 1'b1, 9, 48'd300, 1'b1));
      send_point(make_point(1, 2, 3, 1'b1, 10, 48'd301, 1'b0));
      send_point(make_point(1, 2, 3, 1'b1, 20, 48'd302, 1'b0));
      send_point(make_point(1, 2, 3, 1'b1, 21, 48'd303, 1'b0));
      settle();
      // inverted window drops everything
      write_csr(lpf_pkg::CSR_MIN_INTENSITY, 16'd200);
      write_csr(lpf_pkg::CSR_MAX_INTENSITY, 16'd100);
      send_point(make_point(1, 2, 3, 1'b1, 150, 48'd304, 1'b0));
      settle();
      write_csr(lpf_pkg::CSR_MIN_INTENSITY, 16'd0);
      write_csr(lpf_pkg::CSR_MAX_INTENSITY, 16'd255);
   endtask

   task automatic test_decimation();
      settle();
      write_csr(lpf_pkg::CSR_DECIMATION, 16'd3);
      send_point(make_point(10, 0, 0, 1'b1, 50, 48'd1000, 1'b1));
      send_point(make_point(11, 0, 0, 1'b1, 50, 48'd1001, 1'b0));
      send_point(make_point(12, 0, 0, 1'b1, 50, 48'd1002, 1'b0));
      send_point(make_point(13, 0, 0, 1'b1, 50, 48'd1003, 1'b0));
      // first mark in mid count restarts the index
      send_point(make_point(14, 0, 0, 1'b1, 50, 48'd2000, 1'b1));
      settle();
      // zero acts as one
      write_csr(lpf_pkg::CSR_DECIMATION, 16'd0);
      send_point(make_point(15, 0, 0, 1'b1, 50, 48'd2001, 1'b0));
      send_point(make_point(16, 0, 0, 1'b1, 50, 48'd2002, 1'b0));
      settle();
      // above the maximum acts as the maximum
      write_csr(lpf_pkg::CSR_DECIMATION, 16'd127);
      send_point(make_point(17, 0, 0, 1'b1, 50, 48'd3000, 1'b1));
      send_point(make_point(18, 0, 0, 1'b1, 50, 48'd3001, 1'b0));
   endtask

   task automatic test_random_clouds();
      int unsigned                 sent;
      int unsigned                 cloud_len;
      int unsigned                 lo;
      int unsigned                 hi;
      int unsigned                 tmp;
      logic [lpf_pkg::STAMP_W-1:0] ts;
      bit                          wide;
      lidar_point_type             p;
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         settle();
         case ($urandom_range(0, 5))
            0:       write_csr(lpf_pkg::CSR_DECIMATION, 16'd0);
            1:       write_csr(lpf_pkg::CSR_DECIMATION, 16'd1);
            2:       write_csr(lpf_pkg::CSR_DECIMATION, 16'd64);
            3:       write_csr(lpf_pkg::CSR_DECIMATION, 16'd127);
            default: write_csr(lpf_pkg::CSR_DECIMATION,
                               lpf_pkg::CSR_DATA_W'($urandom_range(2, 6)));
         endcase
         case ($urandom_range(0, 3))
            0:       write_csr(lpf_pkg::CSR_BLIND_DISTANCE, 16'd0);
            1:       write_csr(lpf_pkg::CSR_BLIND_DISTANCE, 16'hFFFF);
            2:       write_csr(lpf_pkg::CSR_BLIND_DISTANCE,
                               lpf_pkg::CSR_DATA_W'($urandom_range(0, 65535)));
            default: write_csr(lpf_pkg::CSR_BLIND_DISTANCE,
                               lpf_pkg::CSR_DATA_W'($urandom_range(0, 40000)));
         endcase
         lo = $urandom_range(0, 255);
         hi = $urandom_range(0, 255);
         if (lo > hi && $urandom_range(0, 4) != 0) begin
            tmp = lo;
            lo = hi;
            hi = tmp;
         end
         write_csr(lpf_pkg::CSR_MIN_INTENSITY, lpf_pkg::CSR_DATA_W'(lo));
         write_csr(lpf_pkg::CSR_MAX_INTENSITY, lpf_pkg::CSR_DATA_W'(hi));
         req_burst = (ph % 3 == 2);
         rsp_burst = (ph % 4 == 3);
         sent = 0;
         while (sent < PHASE_POINTS) begin
            if ($urandom_range(0, 9) == 0) begin
               // noise word: every field random, including the first mark
               p.x = rand_coord(1'b1);
               p.y = rand_coord(1'b1);
               p.z = rand_coord(1'b1);
               p.valid = 1'($urandom_range(0, 1));
               p.refl = lpf_pkg::REFL_W'($urandom_range(0, 255));
               p.stamp = rand_stamp();
               p.first = 1'($urandom_range(0, 1));
               send_point(p);
               sent++;
            end else begin
               cloud_len = $urandom_range(1, 24);
               ts = rand_stamp();
               wide = ($urandom_range(0, 3) == 0);
               for (int k = 0; k < cloud_len; k++) begin
                  p.x = rand_coord(wide);
                  p.y = rand_coord(wide);
                  p.z = rand_coord(wide);
                  p.valid = ($urandom_range(0, 9) != 0);
                  p.refl = lpf_pkg::REFL_W'($urandom_range(0, 255));
                  p.stamp = ts;
                  p.first = (k == 0);
                  send_point(p);
                  ts += lpf_pkg::STAMP_W'($urandom_range(0, 200));
                  sent++;
               end
            end
         end
      end
      req_burst = 1'b0;
      rsp_burst = 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_blind_zone();
      test_intensity_window();
      test_decimation();
      test_random_clouds();
      settle();
      if (n_errors == 0 && pending_words() == 0) begin
         $display("lidar_point_filter_top_tb passed");
      end else begin
         $display("lidar_point_filter_top_tb failed");
      end
      $finish;
   end

endmodule
